>>> rtl/fsp_pkg.sv
// ----------------------------------------------------------------------------
// frame skip pacer package
// widths, codes, reset values and sequencer states shared by the pacer
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int DEF_FINE_TICK_BITS = 48;
    localparam int DEF_MS_TICK_BITS   = 32;

    localparam int TICKS_BITS    = 30;
    localparam int FPS_BITS      = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = TICKS_BITS;
    localparam int REQ_BITS      = 2;

    // ticks_per_ms * 1000 fits in 40 bits, the period times 100 in 47
    localparam int DIVIDEND_BITS = 40;
    localparam int TPF100_BITS   = 47;
    localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

    localparam int MS_PER_SEC        = 1000;
    localparam int CLAMP_FRAMES      = 100;
    localparam int RENDER_OVERDUE_MS = 5000;

    localparam logic [TICKS_BITS-1:0] RST_TICKS_PER_MS = TICKS_BITS'(1000);
    localparam logic [FPS_BITS-1:0]   RST_MAX_FPS      = FPS_BITS'(40);
    localparam logic [FPS_BITS-1:0]   RST_MIN_FPS      = FPS_BITS'(10);
    localparam logic                  RST_RENDER_ONLY  = 1'b1;
    localparam logic                  RST_FIXED_FRAME  = 1'b1;

    localparam logic [REQ_BITS-1:0] REQ_CHECK  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_RESYNC = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REBASE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_MS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_FPS      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_FPS      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RENDER_ONLY  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIXED_FRAME  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_TPF_SCALE,
        ST_CLAMP,
        ST_DECIDE,
        ST_STEP_MIN,
        ST_ADVANCE,
        ST_RENDER,
        ST_DONE
    } fsp_state_t;

    function automatic logic [FPS_BITS-1:0] fps_or_one(input logic [FPS_BITS-1:0] fps);
        fps_or_one = (fps == '0) ? FPS_BITS'(1) : fps;
    endfunction

endpackage

>>> rtl/frame_skip_pacer.sv
// ----------------------------------------------------------------------------
// frame skip pacer
// decides per game loop pass whether to move and whether to render, pacing
// frames against a fine counter with a shared bit-serial period divider
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  req     | req_valid, req_stall | req_type, fine_tick, ms_tick
//  rsp     | rsp_valid, rsp_stall | do_move, do_render, pass_ms
//  cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
//  a check item runs through the divider, tpf scale, clamp and decide states; a
//  due frame goes on through advance and render, in variable mode after a second
//  division and the step-min state; the restoring divider gives one quotient bit
//  a cycle for a 40-bit quotient; resync, rebase and unused items go to done
//  one item at a time; req_stall is high from acceptance until the result is
//  loaded into the output register, which waits while rsp_stall holds it
//  reset restores the register defaults and clears the frame state
// ----------------------------------------------------------------------------
module frame_skip_pacer #(
    parameter int FINE_TICK_BITS = fsp_pkg::DEF_FINE_TICK_BITS,
    parameter int MS_TICK_BITS   = fsp_pkg::DEF_MS_TICK_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [fsp_pkg::REQ_BITS-1:0]       req_type,
    input  logic [FINE_TICK_BITS-1:0]          fine_tick,
    input  logic [MS_TICK_BITS-1:0]            ms_tick,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               do_move,
    output logic                               do_render,
    output logic [MS_TICK_BITS-1:0]            pass_ms,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fsp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import fsp_pkg::*;

    localparam int F = FINE_TICK_BITS;
    localparam int M = MS_TICK_BITS;
    localparam int CMP_BITS = (F > TPF100_BITS) ? F : TPF100_BITS;

    fsp_state_t state_reg, state_next;

    logic [TICKS_BITS-1:0] ticks_per_ms_reg;
    logic [FPS_BITS-1:0]   max_fps_reg;
    logic [FPS_BITS-1:0]   min_fps_reg;
    logic                  render_only_reg;
    logic                  fixed_frame_reg;

    logic [F-1:0] base_reg, base_next;
    logic [M-1:0] last_move_reg, last_move_next;
    logic [M-1:0] last_render_reg, last_render_next;
    logic         seen_reg, seen_next;

    logic [REQ_BITS-1:0] req_reg, req_next;
    logic [F-1:0]        cur_reg, cur_next;
    logic [M-1:0]        ms_reg, ms_next;

    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [FPS_BITS-1:0]      rem_reg, rem_next;
    logic [FPS_BITS-1:0]      den_reg, den_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                     sel_min_reg, sel_min_next;

    logic [DIVIDEND_BITS-1:0] tpf_reg, tpf_next;
    logic [TPF100_BITS-1:0]   tpf100_reg, tpf100_next;
    logic [CMP_BITS-1:0]      elapsed_reg, elapsed_next;
    logic [F-1:0]             step_reg, step_next;

    logic         mv_reg, mv_next;
    logic         rd_reg, rd_next;
    logic [M-1:0] pass_reg, pass_next;

    logic         rsp_valid_reg, rsp_valid_next;
    logic         do_move_reg, do_move_next;
    logic         do_render_reg, do_render_next;
    logic [M-1:0] pass_ms_reg, pass_ms_next;

    logic [DIVIDEND_BITS-1:0] dividend;
    logic [FPS_BITS:0]        rem_shift;
    logic [FPS_BITS-1:0]      min_sel;
    logic [F-1:0]             fine_diff;
    logic [M-1:0]             render_gap;

    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign do_move   = do_move_reg;
    assign do_render = do_render_reg;
    assign pass_ms   = pass_ms_reg;

    assign dividend   = DIVIDEND_BITS'({{(DIVIDEND_BITS-TICKS_BITS){1'b0}}, ticks_per_ms_reg}
                        * DIVIDEND_BITS'(MS_PER_SEC));
    assign rem_shift  = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign min_sel    = (min_fps_reg != '0) ? min_fps_reg : max_fps_reg;
    assign fine_diff  = cur_reg - base_reg;
    assign render_gap = ms_reg - last_render_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_ms_reg <= RST_TICKS_PER_MS;
            max_fps_reg      <= RST_MAX_FPS;
            min_fps_reg      <= RST_MIN_FPS;
            render_only_reg  <= RST_RENDER_ONLY;
            fixed_frame_reg  <= RST_FIXED_FRAME;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_MS: ticks_per_ms_reg <= cfg_data[TICKS_BITS-1:0];
                CFG_MAX_FPS:      max_fps_reg      <= cfg_data[FPS_BITS-1:0];
                CFG_MIN_FPS:      min_fps_reg      <= cfg_data[FPS_BITS-1:0];
                CFG_RENDER_ONLY:  render_only_reg  <= cfg_data[0];
                CFG_FIXED_FRAME:  fixed_frame_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            base_reg        <= '0;
            last_move_reg   <= '0;
            last_render_reg <= '0;
            seen_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            sel_min_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            base_reg        <= base_next;
            last_move_reg   <= last_move_next;
            last_render_reg <= last_render_next;
            seen_reg        <= seen_next;
            rsp_valid_reg   <= rsp_valid_next;
            cnt_reg         <= cnt_next;
            sel_min_reg     <= sel_min_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        cur_reg       <= cur_next;
        ms_reg        <= ms_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        tpf_reg       <= tpf_next;
        tpf100_reg    <= tpf100_next;
        elapsed_reg   <= elapsed_next;
        step_reg      <= step_next;
        mv_reg        <= mv_next;
        rd_reg        <= rd_next;
        pass_reg      <= pass_next;
        do_move_reg   <= do_move_next;
        do_render_reg <= do_render_next;
        pass_ms_reg   <= pass_ms_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        base_next        = base_reg;
        last_move_next   = last_move_reg;
        last_render_next = last_render_reg;
        seen_next        = seen_reg;
        req_next         = req_reg;
        cur_next         = cur_reg;
        ms_next          = ms_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        cnt_next         = cnt_reg;
        sel_min_next     = sel_min_reg;
        tpf_next         = tpf_reg;
        tpf100_next      = tpf100_reg;
        elapsed_next     = elapsed_reg;
        step_next        = step_reg;
        mv_next          = mv_reg;
        rd_next          = rd_reg;
        pass_next        = pass_reg;
        do_move_next     = do_move_reg;
        do_render_next   = do_render_reg;
        pass_ms_next     = pass_ms_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_type;
                    cur_next   = fine_tick;
                    ms_next    = ms_tick;
                    mv_next    = 1'b0;
                    rd_next    = 1'b0;
                    pass_next  = '0;
                    state_next = ST_DONE;
                    case (req_type)
                        REQ_RESYNC:
                        begin
                            base_next      = fine_tick;
                            last_move_next = ms_tick;
                        end
                        REQ_REBASE:
                        begin
                            base_next = fine_tick;
                        end
                        REQ_CHECK:
                        begin
                            quo_next     = dividend;
                            rem_next     = '0;
                            den_next     = fps_or_one(max_fps_reg);
                            cnt_next     = '0;
                            sel_min_next = 1'b0;
                            state_next   = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end

            // restoring division, one quotient bit a cycle
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, den_reg})
                begin
                    rem_next = FPS_BITS'(rem_shift - {1'b0, den_reg});
                    quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[FPS_BITS-1:0];
                    quo_next = {quo_reg[DIVIDEND_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(DIVIDEND_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = sel_min_reg ? ST_STEP_MIN : ST_TPF_SCALE;
                end
            end

            ST_TPF_SCALE:
            begin
                tpf_next     = quo_reg;
                tpf100_next  = TPF100_BITS'({{(TPF100_BITS-DIVIDEND_BITS){1'b0}}, quo_reg}
                               * TPF100_BITS'(CLAMP_FRAMES));
                elapsed_next = CMP_BITS'(fine_diff);
                state_next   = ST_CLAMP;
            end

            // too far behind: pretend exactly one frame has passed
            ST_CLAMP:
            begin
                if (elapsed_reg > CMP_BITS'(tpf100_reg))
                begin
                    elapsed_next = CMP_BITS'(tpf_reg);
                    base_next    = cur_reg - F'(tpf_reg);
                end
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (elapsed_reg >= CMP_BITS'(tpf_reg))
                begin
                    if (fixed_frame_reg)
                    begin
                        step_next  = F'(tpf_reg);
                        state_next = ST_ADVANCE;
                    end
                    else
                    begin
                        quo_next     = dividend;
                        rem_next     = '0;
                        den_next     = fps_or_one(min_sel);
                        cnt_next     = '0;
                        sel_min_next = 1'b1;
                        state_next   = ST_DIV;
                    end
                end
                else
                begin
                    if (render_only_reg)
                    begin
                        pass_next        = M'(1);
                        last_render_next = ms_reg;
                        rd_next          = 1'b1;
                        mv_next          = !seen_reg;
                    end
                    state_next = ST_DONE;
                end
            end

            // variable mode: elapsed time capped at the minimum-rate period
            ST_STEP_MIN:
            begin
                if (elapsed_reg < CMP_BITS'(quo_reg))
                    step_next = F'(elapsed_reg);
                else
                    step_next = F'(quo_reg);
                state_next = ST_ADVANCE;
            end

            ST_ADVANCE:
            begin
                base_next      = base_reg + step_reg;
                seen_next      = 1'b1;
                pass_next      = ms_reg - last_move_reg;
                last_move_next = ms_reg;
                mv_next        = 1'b1;
                state_next     = ST_RENDER;
            end

            ST_RENDER:
            begin
                if ((CMP_BITS'(fine_diff) <= CMP_BITS'(tpf_reg))
                    || (render_gap > M'(RENDER_OVERDUE_MS)))
                begin
                    last_render_next = ms_reg;
                    rd_next          = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    do_move_next   = mv_reg;
                    do_render_next = rd_reg;
                    pass_ms_next   = pass_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> bench/frame_skip_pacer_test.sv
// ----------------------------------------------------------------------------
// frame skip pacer testbench
// drives check, resync, rebase and unused items through the pacer under
// several register settings, with random idle cycles on both channels;
// a scoreboard works out the move, render and pass_ms decision for every
// accepted item and compares it with each result that comes back
// ----------------------------------------------------------------------------
module frame_skip_pacer_test;

    import fsp_pkg::*;

    localparam int FB = DEF_FINE_TICK_BITS;
    localparam int MB = DEF_MS_TICK_BITS;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    typedef logic [FB-1:0] fine_t;
    typedef logic [MB-1:0] ms_t;
    typedef logic [63:0]   wide_t;

    typedef struct packed {
        logic move;
        logic render;
        ms_t  pass;
    } decision_t;

    class pacing_scoreboard;
        logic [TICKS_BITS-1:0] ticks_per_ms;
        logic [FPS_BITS-1:0]   max_fps;
        logic [FPS_BITS-1:0]   min_fps;
        logic                  render_only;
        logic                  fixed_frame;
        fine_t                 frame_base;
        ms_t                   last_move;
        ms_t                   last_render;
        logic                  frame_seen;
        decision_t             due_decisions[$];
        int                    errors;

        function new();
            ticks_per_ms = RST_TICKS_PER_MS;
            max_fps      = RST_MAX_FPS;
            min_fps      = RST_MIN_FPS;
            render_only  = RST_RENDER_ONLY;
            fixed_frame  = RST_FIXED_FRAME;
            frame_base   = '0;
            last_move    = '0;
            last_render  = '0;
            frame_seen   = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_TICKS_PER_MS: ticks_per_ms = data[TICKS_BITS-1:0];
                CFG_MAX_FPS:      max_fps      = data[FPS_BITS-1:0];
                CFG_MIN_FPS:      min_fps      = data[FPS_BITS-1:0];
                CFG_RENDER_ONLY:  render_only  = data[0];
                CFG_FIXED_FRAME:  fixed_frame  = data[0];
                default:          ;
            endcase
        endfunction

        function wide_t frame_period(logic [FPS_BITS-1:0] fps);
            wide_t divisor;
            divisor = (fps == '0) ? 64'd1 : wide_t'(fps);
            return (wide_t'(ticks_per_ms) * MS_PER_SEC) / divisor;
        endfunction

        function void note_request(logic [REQ_BITS-1:0] kind, fine_t fine, ms_t ms);
            decision_t res;
            wide_t     tpf;
            wide_t     min_tpf;
            wide_t     elapsed;
            wide_t     advance;
            res = '0;
            case (kind)
                REQ_RESYNC:
                begin
                    frame_base = fine;
                    last_move  = ms;
                end
                REQ_REBASE:
                begin
                    frame_base = fine;
                end
                REQ_CHECK:
                begin
                    tpf     = frame_period(max_fps);
                    elapsed = wide_t'(fine_t'(fine - frame_base));
                    if (elapsed > tpf * CLAMP_FRAMES)
                    begin
                        elapsed    = tpf;
                        frame_base = fine_t'(fine - fine_t'(tpf));
                    end
                    if (elapsed >= tpf)
                    begin
                        if (!fixed_frame)
                        begin
                            min_tpf = frame_period((min_fps != '0) ? min_fps : max_fps);
                            advance = (elapsed < min_tpf) ? elapsed : min_tpf;
                        end
                        else
                        begin
                            advance = tpf;
                        end
                        frame_base = fine_t'(frame_base + fine_t'(advance));
                        frame_seen = 1'b1;
                        res.pass   = ms_t'(ms - last_move);
                        last_move  = ms;
                        res.move   = 1'b1;
                        if (wide_t'(fine_t'(fine - frame_base)) <= tpf ||
                            ms_t'(ms - last_render) > RENDER_OVERDUE_MS)
                        begin
                            last_render = ms;
                            res.render  = 1'b1;
                        end
                    end
                    else if (render_only)
                    begin
                        res.pass    = 1;
                        last_render = ms;
                        res.render  = 1'b1;
                        res.move    = !frame_seen;
                    end
                end
                default:
                    ;
            endcase
            due_decisions.push_back(res);
        endfunction

        function void check_result(logic move, logic render, ms_t pass);
            decision_t want;
            if (due_decisions.size() == 0)
            begin
                $display("%0t: unexpected result move=%b render=%b pass_ms=%0d",
                         $time, move, render, pass);
                errors++;
                return;
            end
            want = due_decisions.pop_front();
            if (move !== want.move)
            begin
                $display("%0t: do_move expected %b actual %b", $time, want.move, move);
                errors++;
            end
            if (render !== want.render)
            begin
                $display("%0t: do_render expected %b actual %b", $time, want.render, render);
                errors++;
            end
            if (pass !== want.pass)
            begin
                $display("%0t: pass_ms expected %0d actual %0d", $time, want.pass, pass);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    logic [REQ_BITS-1:0]       req_type;
    fine_t                     fine_tick;
    ms_t                       ms_tick;
    logic                      rsp_valid;
    logic                      rsp_stall;
    logic                      do_move;
    logic                      do_render;
    ms_t                       pass_ms;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    pacing_scoreboard sb;
    fine_t now_fine;
    ms_t   now_ms;
    int    req_calm;
    int    rsp_calm;
    int    idle_cycles;

    frame_skip_pacer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .fine_tick (fine_tick),
        .ms_tick   (ms_tick),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .do_move   (do_move),
        .do_render (do_render),
        .pass_ms   (pass_ms),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic wide_t rand_wide();
        return {$urandom, $urandom};
    endfunction

    // runs of zero gaps now and then, otherwise a mix of short and long gaps
    function automatic int idle_draw(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(10, 50);
            return 0;
        end
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    task automatic send_req(input logic [REQ_BITS-1:0] kind, input fine_t fine, input ms_t ms);
        int gap;
        gap = idle_draw(req_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        fine_tick <= fine;
        ms_tick   <= ms;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(kind, fine, ms);
    endtask

    task automatic req_quiet();
        req_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [CFG_DATA_BITS-1:0] ticks,
                                 input logic [CFG_DATA_BITS-1:0] max_data,
                                 input logic [CFG_DATA_BITS-1:0] min_data,
                                 input logic [CFG_DATA_BITS-1:0] ro_data,
                                 input logic [CFG_DATA_BITS-1:0] fixed_data);
        logic [CFG_IDX_BITS-1:0]  idxs [5];
        logic [CFG_DATA_BITS-1:0] vals [5];
        idxs = '{CFG_TICKS_PER_MS, CFG_MAX_FPS, CFG_MIN_FPS, CFG_RENDER_ONLY, CFG_FIXED_FRAME};
        vals = '{ticks, max_data, min_data, ro_data, fixed_data};
        while (sb.due_decisions.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly checks that follow a running clock, with resyncs, rebases and noise
    task automatic run_phase(input int count);
        wide_t tpf;
        wide_t adv;
        ms_t   dms;
        int    pick;
        fine_t noise_fine;
        ms_t   noise_ms;
        tpf      = sb.frame_period(sb.max_fps);
        now_fine = fine_t'(rand_wide());
        now_ms   = $urandom;
        send_req(REQ_RESYNC, now_fine, now_ms);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        adv = rand_wide() % (tpf + 1);
                    8, 9, 10, 11, 12, 13:
                        adv = tpf + rand_wide() % (tpf / 4 + 1);
                    14, 15:
                        adv = tpf * $urandom_range(2, 5) + rand_wide() % (tpf + 1);
                    16:
                        adv = tpf * $urandom_range(90, 110);
                    17:
                        adv = wide_t'(fine_t'(-(rand_wide() % (tpf * 4 + 2))));
                    18:
                        case ($urandom_range(0, 3))
                            0:       adv = tpf;
                            1:       adv = tpf - 1;
                            2:       adv = tpf * CLAMP_FRAMES;
                            default: adv = tpf * CLAMP_FRAMES + 1;
                        endcase
                    default:
                        adv = rand_wide();
                endcase
                if (sb.ticks_per_ms != '0)
                    dms = ms_t'(wide_t'(fine_t'(adv)) / wide_t'(sb.ticks_per_ms));
                else
                    dms = $urandom_range(0, 100);
                if ($urandom_range(0, 11) == 0)
                    dms = dms + $urandom_range(0, 12000);
                now_fine = fine_t'(now_fine + fine_t'(adv));
                now_ms   = now_ms + dms;
                send_req(REQ_CHECK, now_fine, now_ms);
            end
            else if (pick < 82)
                send_req(REQ_RESYNC, now_fine, now_ms);
            else if (pick < 90)
                send_req(REQ_REBASE, now_fine, now_ms + $urandom_range(0, 50));
            else if (pick < 95)
                send_req(REQ_UNUSED, fine_t'(rand_wide()), $urandom);
            else
            begin
                noise_fine = fine_t'(rand_wide());
                noise_ms   = $urandom;
                send_req(REQ_CHECK, noise_fine, noise_ms);
                now_fine = noise_fine;
                now_ms   = noise_ms;
            end
        end
        req_quiet();
    endtask

    task automatic random_phase(input int count);
        logic [TICKS_BITS-1:0] ticks;
        logic [FPS_BITS-1:0]   max_f;
        logic [FPS_BITS-1:0]   min_f;
        ticks = $urandom_range(0, 1) ? TICKS_BITS'($urandom_range(1, 200000))
                                     : TICKS_BITS'($urandom);
        max_f = ($urandom_range(0, 3) == 0) ? FPS_BITS'($urandom_range(0, 1023))
                                            : FPS_BITS'($urandom_range(1, 120));
        min_f = ($urandom_range(0, 2) == 0) ? FPS_BITS'(0) : FPS_BITS'($urandom_range(0, 1023));
        load_settings(ticks, {20'($urandom), max_f}, {20'($urandom), min_f},
                      30'($urandom), 30'($urandom));
        run_phase(count);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = idle_draw(rsp_calm);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            sb.check_result(do_move, do_render, pass_ms);
        end
    end

    initial
    begin
        sb          = new();
        req_calm    = 0;
        rsp_calm    = 0;
        idle_cycles = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_type  <= REQ_CHECK;
        fine_tick <= '0;
        ms_tick   <= '0;
        rsp_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TICKS_PER_MS;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 25000 ticks per frame, 100000 for the minimum rate
        send_req(REQ_CHECK,  48'd0,      32'd0);
        send_req(REQ_CHECK,  48'd10000,  32'd10);
        send_req(REQ_CHECK,  48'd25000,  32'd25);
        send_req(REQ_CHECK,  48'd30000,  32'd30);
        send_req(REQ_UNUSED, '1,         '1);
        send_req(REQ_CHECK,  48'd50000,  32'd50);
        send_req(REQ_CHECK,  48'd200000, 32'd200);
        send_req(REQ_CHECK,  48'd230000, 32'd230);
        send_req(REQ_RESYNC, 48'd300000, 32'd1000);
        send_req(REQ_REBASE, 48'd310000, 32'd0);
        send_req(REQ_CHECK,  '1,         32'hFFFF_FFF0);
        send_req(REQ_CHECK,  48'd0,      32'd5);
        send_req(REQ_CHECK,  48'd24999,  32'd30);
        send_req(REQ_CHECK,  48'd90000,  32'd9000);
        send_req(REQ_CHECK,  48'd1000000, 32'd9010);
        send_req(REQ_CHECK,  48'd1000000 + 48'd2500000, 32'd9020);
        send_req(REQ_CHECK,  48'h8000_0000_0000, 32'h8000_0000);
        send_req(REQ_REBASE, 48'h5555_5555_5555, 32'hAAAA_AAAA);
        send_req(REQ_CHECK,  48'h5555_5555_5555 + 48'd25000, 32'h5555_5555);
        send_req(REQ_CHECK,  48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        send_req(REQ_RESYNC, 48'h7FFF_FFFF_0000, 32'h7FFF_FFFF);
        send_req(REQ_CHECK,  48'h7FFF_FFFF_0000 + 48'd25000, 32'h8000_0018);
        req_quiet();

        load_settings(30'd1000, 30'd60, 30'd0, 30'd0, 30'd0);
        run_phase(230);
        load_settings('1, 30'd1, 30'd999, 30'd1, 30'd0);
        run_phase(200);
        load_settings(30'd0, 30'd0, 30'd0, 30'd1, 30'd1);
        run_phase(150);
        load_settings(30'd1, 30'd999, 30'd1, 30'd0, 30'd1);
        run_phase(200);
        load_settings(30'd48000, 30'd1023, 30'd1023, 30'd1, 30'd0);
        run_phase(200);
        repeat (4) random_phase(230);

        while (sb.due_decisions.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.due_decisions.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
